// ===== sv/sqe_pkg.sv =====
package sqe_pkg;

   // opcodes with a meaning of their own
   localparam logic [7:0] OP_SET_LENGTH     = 8'h00;
   localparam logic [7:0] OP_SET_VOICES     = 8'h01;
   localparam logic [7:0] OP_CALL           = 8'h02;
   localparam logic [7:0] OP_RETURN         = 8'h03;
   localparam logic [7:0] OP_SET_MULTIPLIER = 8'h04;
   localparam logic [7:0] OP_REPEAT_START_0 = 8'h06;
   localparam logic [7:0] OP_REPEAT_END_0   = 8'h07;
   localparam logic [7:0] OP_JUMP           = 8'h08;
   localparam logic [7:0] OP_NOTE           = 8'h09;
   localparam logic [7:0] OP_VOICE_BLOCK    = 8'h0B;
   localparam logic [7:0] OP_TIE            = 8'h0E;
   localparam logic [7:0] OP_REPEAT_START_1 = 8'h0F;
   localparam logic [7:0] OP_REPEAT_END_1   = 8'h10;
   localparam logic [7:0] OP_TABLE_LAST     = 8'h14;
   localparam logic [7:0] OP_BLOCK_FIRST    = 8'h18;
   localparam logic [7:0] OP_BLOCK_LAST     = 8'h97;

   localparam logic [7:0] NO_NOTE = 8'hFF;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned DURATION_W = 16;
   localparam int unsigned COUNT_W    = 9;
   localparam int unsigned TARGET_W   = 16;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_NOTE    = 2'd1,
      KIND_REST    = 2'd2,
      KIND_TIE     = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      FLOW_NONE         = 3'd0,
      FLOW_CALL         = 3'd1,
      FLOW_RETURN       = 3'd2,
      FLOW_JUMP         = 3'd3,
      FLOW_REPEAT_START = 3'd4,
      FLOW_REPEAT_END   = 3'd5
   } flow_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     opcode;
      logic [POS_W-1:0]      event_bytes;
      event_kind_type        event_kind;
      logic [DURATION_W-1:0] duration;
      logic [BYTE_W-1:0]     note_byte;
      flow_kind_type         flow_kind;
      logic [COUNT_W-1:0]    repeat_count;
      logic                  repeat_slot;
      logic [TARGET_W-1:0]   target_address;
      logic [BYTE_W-1:0]     voice_mask;
   } event_type;

   // opcodes followed by a voice mask byte
   function automatic logic has_mask(input logic [7:0] op);
      return (op == OP_NOTE) || (op == OP_VOICE_BLOCK) ||
             ((op >= OP_BLOCK_FIRST) && (op <= OP_BLOCK_LAST));
   endfunction

   // length from the opcode alone; mask opcodes give 0 until the mask arrives
   function automatic logic [POS_W-1:0] opcode_length(input logic [7:0] op);
      logic [POS_W-1:0] len;
      len = 4'd1;
      if (has_mask(op)) begin
         len = 4'd0;
      end else if (op <= OP_TABLE_LAST) begin
         unique case (op[4:0])
            5'h00, 5'h01, 5'h04, 5'h05, 5'h0A, 5'h0C, 5'h0D,
            5'h11, 5'h12, 5'h13, 5'h14: len = 4'd2;
            5'h02, 5'h08:               len = 4'd3;
            5'h06, 5'h07, 5'h0F, 5'h10: len = 4'd4;
            default:                    len = 4'd1;
         endcase
      end
      return len;
   endfunction

   function automatic logic [POS_W-1:0] mask_length(input logic [7:0] mask);
      logic [POS_W-1:0] n;
      n = 4'd2;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, mask[i]};
      end
      return n;
   endfunction

endpackage

// ===== sv/sqe_if.sv =====
interface sqe_req_if;
   logic                        valid;
   logic                        ready;
   logic [sqe_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface sqe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sqe_pkg::BYTE_W-1:0]     opcode;
   logic [sqe_pkg::POS_W-1:0]      event_bytes;
   logic [1:0]                     event_kind;
   logic [sqe_pkg::DURATION_W-1:0] duration;
   logic [sqe_pkg::BYTE_W-1:0]     note_byte;
   logic [2:0]                     flow_kind;
   logic [sqe_pkg::COUNT_W-1:0]    repeat_count;
   logic                           repeat_slot;
   logic [sqe_pkg::TARGET_W-1:0]   target_address;
   logic [sqe_pkg::BYTE_W-1:0]     voice_mask;

   modport source (output valid, output opcode, output event_bytes, output event_kind,
                   output duration, output note_byte, output flow_kind,
                   output repeat_count, output repeat_slot, output target_address,
                   output voice_mask, input ready);
   modport sink   (input valid, input opcode, input event_bytes, input event_kind,
                   input duration, input note_byte, input flow_kind,
                   input repeat_count, input repeat_slot, input target_address,
                   input voice_mask, output ready);
endinterface

// ===== sv/sequence_event_decoder.sv =====
// channel  dir  transaction payload
// -------  ---  -------------------------------------------------------------
// req      in   data_byte: one byte of the event stream
// rsp      out  one finished event: opcode, length, kind, duration, note,
//               flow kind, repeat count/slot, target address, voice mask
//
// one byte per cycle sustained while rsp does not stall; each accepted byte is held in the input
// register, then the framer decodes it and closes the event into the output
// register, so each result passes the input register and then the output register
// synchronous active-high reset clears framing state and both valid flags
// when rsp stalls, the input register holds and req.ready drops until the
// output register is taken; nothing is dropped or repeated
module sequence_event_decoder (
   input logic       clock,
   input logic       reset,
   sqe_req_if.sink   req_chan,
   sqe_rsp_if.source rsp_chan
);

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [sqe_pkg::BYTE_W-1:0] in_byte_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   sqe_pkg::event_type  rsp_data_ff;

   logic                step;
   logic                done;
   sqe_pkg::event_type  result;

   // a held byte moves on when the output register is free or being emptied
   assign step           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = req_chan.valid ? 1'b1 : (in_valid_ff && !step);
      if (step) begin
         rsp_valid_in = done;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   sqe_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .done      (done),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
      if (step && done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.opcode         = rsp_data_ff.opcode;
   assign rsp_chan.event_bytes    = rsp_data_ff.event_bytes;
   assign rsp_chan.event_kind     = rsp_data_ff.event_kind;
   assign rsp_chan.duration       = rsp_data_ff.duration;
   assign rsp_chan.note_byte      = rsp_data_ff.note_byte;
   assign rsp_chan.flow_kind      = rsp_data_ff.flow_kind;
   assign rsp_chan.repeat_count   = rsp_data_ff.repeat_count;
   assign rsp_chan.repeat_slot    = rsp_data_ff.repeat_slot;
   assign rsp_chan.target_address = rsp_data_ff.target_address;
   assign rsp_chan.voice_mask     = rsp_data_ff.voice_mask;

endmodule

// ===== sv/sqe_framer.sv =====
module sqe_framer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [sqe_pkg::BYTE_W-1:0] data_byte,
   output logic                       done,
   output sqe_pkg::event_type         result
);

   logic [sqe_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [sqe_pkg::BYTE_W-1:0] opcode_ff, opcode_in;
   logic [sqe_pkg::POS_W-1:0]  length_ff, length_in;
   logic [sqe_pkg::BYTE_W-1:0] operand1_ff, operand1_in;
   logic [sqe_pkg::BYTE_W-1:0] operand2_ff, operand2_in;
   logic [sqe_pkg::BYTE_W-1:0] operand3_ff, operand3_in;
   logic [sqe_pkg::BYTE_W-1:0] first_note_ff, first_note_in;
   logic [sqe_pkg::BYTE_W-1:0] note_length_ff, note_length_in;
   logic [sqe_pkg::BYTE_W-1:0] multiplier_ff, multiplier_in;
   logic [sqe_pkg::BYTE_W-1:0] voices_ff, voices_in;

   logic                          at_start;
   logic [sqe_pkg::POS_W-1:0]     pos_inc;
   logic [sqe_pkg::BYTE_W-1:0]    mult_eff;
   logic [sqe_pkg::DURATION_W-1:0] product;

   always_comb begin
      at_start    = (pos_ff == '0);
      opcode_in   = at_start ? data_byte : opcode_ff;
      operand1_in = (pos_ff == 4'd1) ? data_byte : operand1_ff;
      operand2_in = (pos_ff == 4'd2) ? data_byte : operand2_ff;
      operand3_in = (pos_ff == 4'd3) ? data_byte : operand3_ff;

      if (at_start) begin
         length_in = sqe_pkg::opcode_length(data_byte);
      end else if ((pos_ff == 4'd1) && sqe_pkg::has_mask(opcode_ff)) begin
         length_in = sqe_pkg::mask_length(data_byte);
      end else begin
         length_in = length_ff;
      end

      if (at_start) begin
         first_note_in = sqe_pkg::NO_NOTE;
      end else if ((pos_ff >= 4'd2) && (opcode_ff == sqe_pkg::OP_NOTE) &&
                   (first_note_ff == sqe_pkg::NO_NOTE) && (data_byte != sqe_pkg::NO_NOTE)) begin
         first_note_in = data_byte;
      end else begin
         first_note_in = first_note_ff;
      end

      pos_inc = pos_ff + 4'd1;
      done    = at_start ? (length_in == 4'd1) : (pos_inc >= length_in);
      pos_in  = done ? '0 : pos_inc;

      // settings commands land when their event closes
      note_length_in = note_length_ff;
      multiplier_in  = multiplier_ff;
      voices_in      = voices_ff;
      if (done) begin
         if (opcode_in == sqe_pkg::OP_SET_LENGTH)     note_length_in = operand1_in;
         if (opcode_in == sqe_pkg::OP_SET_VOICES)     voices_in      = operand1_in;
         if (opcode_in == sqe_pkg::OP_SET_MULTIPLIER) multiplier_in  = operand1_in;
      end

      mult_eff = (multiplier_ff == '0) ? 8'd1 : multiplier_ff;
      product  = {8'h00, note_length_ff} * {8'h00, mult_eff};

      result                = '0;
      result.opcode         = opcode_in;
      result.event_bytes    = length_in;
      result.event_kind     = sqe_pkg::KIND_COMMAND;
      result.note_byte      = sqe_pkg::NO_NOTE;
      result.flow_kind      = sqe_pkg::FLOW_NONE;
      result.voice_mask     = voices_in;

      if ((opcode_in == sqe_pkg::OP_NOTE) || (opcode_in == sqe_pkg::OP_TIE)) begin
         result.duration = (product == '0) ? 16'd1 : product;
         if (opcode_in == sqe_pkg::OP_TIE) begin
            result.event_kind = sqe_pkg::KIND_TIE;
         end else if (first_note_in == sqe_pkg::NO_NOTE) begin
            result.event_kind = sqe_pkg::KIND_REST;
         end else begin
            result.event_kind = sqe_pkg::KIND_NOTE;
            result.note_byte  = first_note_in;
         end
      end

      case (opcode_in)
         sqe_pkg::OP_CALL: begin
            result.flow_kind      = sqe_pkg::FLOW_CALL;
            result.repeat_count   = 9'd1;
            result.target_address = {operand2_in, operand1_in};
         end
         sqe_pkg::OP_RETURN: result.flow_kind = sqe_pkg::FLOW_RETURN;
         sqe_pkg::OP_JUMP: begin
            result.flow_kind      = sqe_pkg::FLOW_JUMP;
            result.target_address = {operand2_in, operand1_in};
         end
         sqe_pkg::OP_REPEAT_START_0, sqe_pkg::OP_REPEAT_START_1,
         sqe_pkg::OP_REPEAT_END_0, sqe_pkg::OP_REPEAT_END_1: begin
            result.flow_kind = ((opcode_in == sqe_pkg::OP_REPEAT_START_0) ||
                                (opcode_in == sqe_pkg::OP_REPEAT_START_1)) ?
                               sqe_pkg::FLOW_REPEAT_START : sqe_pkg::FLOW_REPEAT_END;
            // a zero count means a full 256 passes
            result.repeat_count   = (operand1_in == '0) ? 9'd256 : {1'b0, operand1_in};
            result.repeat_slot    = (opcode_in == sqe_pkg::OP_REPEAT_START_1) ||
                                    (opcode_in == sqe_pkg::OP_REPEAT_END_1);
            result.target_address = {operand3_in, operand2_in};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         opcode_ff      <= '0;
         length_ff      <= '0;
         first_note_ff  <= sqe_pkg::NO_NOTE;
         note_length_ff <= '0;
         multiplier_ff  <= '0;
         voices_ff      <= '0;
      end else if (step) begin
         pos_ff         <= pos_in;
         opcode_ff      <= opcode_in;
         length_ff      <= length_in;
         first_note_ff  <= first_note_in;
         note_length_ff <= note_length_in;
         multiplier_ff  <= multiplier_in;
         voices_ff      <= voices_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         operand1_ff <= operand1_in;
         operand2_ff <= operand2_in;
         operand3_ff <= operand3_in;
      end
   end

endmodule

// ===== test/sequence_event_decoder_tb.sv =====
`timescale 1ns / 100ps

module sequence_event_decoder_tb;

   // opcodes that frame as a one-byte command with no effect
   localparam logic [7:0] OP_UNKNOWN_LOW_FIRST  = 8'h15;
   localparam logic [7:0] OP_UNKNOWN_LOW_LAST   = 8'h17;
   localparam logic [7:0] OP_UNKNOWN_HIGH_FIRST = 8'h98;
   localparam logic [7:0] OP_UNKNOWN_HIGH_LAST  = 8'hFF;

   localparam int PHASE_COUNT    = 5;
   localparam int PHASE_BYTES    = 240;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 4000;

   // one row of the directed table; want is only used when typed is set
   typedef struct {
      logic [7:0]         data_byte;
      bit                 typed;
      sqe_pkg::event_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sqe_req_if req_bus ();
   sqe_rsp_if rsp_bus ();

   sequence_event_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // event framer model: its own copy of the decoder state
   // ------------------------------------------------------------------
   logic [3:0] frame_pos    = 4'd0;
   logic [7:0] frame_op     = 8'h00;
   logic [3:0] frame_len    = 4'd0;
   logic [7:0] operand_a    = 8'h00;
   logic [7:0] operand_b    = 8'h00;
   logic [7:0] operand_c    = 8'h00;
   logic [7:0] lead_note    = sqe_pkg::NO_NOTE;
   logic [7:0] note_ticks   = 8'h00;
   logic [7:0] tick_scale   = 8'h00;
   logic [7:0] active_voice = 8'h00;

   sqe_pkg::event_type pending_events[$];
   stim_row_type       dir_table[$];

   int idle_pct       = 0;
   int stall_pct      = 0;
   int bytes_sent     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   function automatic bit takes_mask(input logic [7:0] op);
      return op == sqe_pkg::OP_NOTE || op == sqe_pkg::OP_VOICE_BLOCK ||
             (op >= sqe_pkg::OP_BLOCK_FIRST && op <= sqe_pkg::OP_BLOCK_LAST);
   endfunction

   // length known from the opcode; mask opcodes learn theirs from the mask byte
   function automatic logic [3:0] event_length_of(input logic [7:0] op);
      if (takes_mask(op)) return 4'd0;
      if (op > sqe_pkg::OP_TABLE_LAST) return 4'd1;
      case (op)
         sqe_pkg::OP_CALL, sqe_pkg::OP_JUMP: return 4'd3;
         sqe_pkg::OP_REPEAT_START_0, sqe_pkg::OP_REPEAT_END_0,
         sqe_pkg::OP_REPEAT_START_1, sqe_pkg::OP_REPEAT_END_1: return 4'd4;
         sqe_pkg::OP_RETURN, sqe_pkg::OP_TIE: return 4'd1;
         default: return 4'd2;
      endcase
   endfunction

   function automatic sqe_pkg::event_type event_of(
         input logic [7:0] op, input logic [3:0] n,
         input sqe_pkg::event_kind_type k, input logic [15:0] d,
         input logic [7:0] nb, input sqe_pkg::flow_kind_type f,
         input logic [8:0] c, input logic s,
         input logic [15:0] t, input logic [7:0] v);
      sqe_pkg::event_type e;
      e.opcode         = op;
      e.event_bytes    = n;
      e.event_kind     = k;
      e.duration       = d;
      e.note_byte      = nb;
      e.flow_kind      = f;
      e.repeat_count   = c;
      e.repeat_slot    = s;
      e.target_address = t;
      e.voice_mask     = v;
      return e;
   endfunction

   // append one row to the directed table
   function automatic void add_row(input logic [7:0] b, input bit typed,
                                   input sqe_pkg::event_type want);
      stim_row_type row;
      row.data_byte = b;
      row.typed     = typed;
      row.want      = want;
      dir_table     = {dir_table, row};
   endfunction

   // describe the event just completed, then apply any setting it carries
   function automatic sqe_pkg::event_type close_event();
      sqe_pkg::event_type e;
      logic [15:0]        scale;
      logic [15:0]        ticks;
      e = event_of(frame_op, frame_len, sqe_pkg::KIND_COMMAND, 16'd0, sqe_pkg::NO_NOTE,
                   sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'h00);
      if (frame_op == sqe_pkg::OP_NOTE || frame_op == sqe_pkg::OP_TIE) begin
         // settings in force before this event; zero multiplier counts as one
         scale = (tick_scale == 8'h00) ? 16'd1 : {8'h00, tick_scale};
         ticks = {8'h00, note_ticks} * scale;
         e.duration = (ticks == 16'd0) ? 16'd1 : ticks;
         if (frame_op == sqe_pkg::OP_TIE) begin
            e.event_kind = sqe_pkg::KIND_TIE;
         end else if (lead_note == sqe_pkg::NO_NOTE) begin
            e.event_kind = sqe_pkg::KIND_REST;
         end else begin
            e.event_kind = sqe_pkg::KIND_NOTE;
            e.note_byte  = lead_note;
         end
      end else begin
         case (frame_op)
            sqe_pkg::OP_SET_LENGTH:     note_ticks   = operand_a;
            sqe_pkg::OP_SET_VOICES:     active_voice = operand_a;
            sqe_pkg::OP_SET_MULTIPLIER: tick_scale   = operand_a;
            sqe_pkg::OP_CALL: begin
               e.flow_kind      = sqe_pkg::FLOW_CALL;
               e.repeat_count   = 9'd1;
               e.target_address = {operand_b, operand_a};
            end
            sqe_pkg::OP_RETURN: e.flow_kind = sqe_pkg::FLOW_RETURN;
            sqe_pkg::OP_JUMP: begin
               e.flow_kind      = sqe_pkg::FLOW_JUMP;
               e.target_address = {operand_b, operand_a};
            end
            sqe_pkg::OP_REPEAT_START_0, sqe_pkg::OP_REPEAT_START_1,
            sqe_pkg::OP_REPEAT_END_0, sqe_pkg::OP_REPEAT_END_1: begin
               e.flow_kind = (frame_op == sqe_pkg::OP_REPEAT_START_0 ||
                              frame_op == sqe_pkg::OP_REPEAT_START_1) ?
                             sqe_pkg::FLOW_REPEAT_START : sqe_pkg::FLOW_REPEAT_END;
               // a zero count means 256 passes
               e.repeat_count   = (operand_a == 8'h00) ? 9'd256 : {1'b0, operand_a};
               e.repeat_slot    = (frame_op == sqe_pkg::OP_REPEAT_START_1 ||
                                   frame_op == sqe_pkg::OP_REPEAT_END_1);
               e.target_address = {operand_c, operand_b};
            end
            default: ;
         endcase
      end
      e.voice_mask = active_voice;
      frame_pos = 4'd0;
      return e;
   endfunction

   // advance the framer by one byte; returns 1 when an event completes
   function automatic bit frame_byte(input logic [7:0] b, output sqe_pkg::event_type done);
      done = '0;
      if (frame_pos == 4'd0) begin
         frame_op  = b;
         lead_note = sqe_pkg::NO_NOTE;
         frame_len = event_length_of(b);
         frame_pos = 4'd1;
         if (frame_len == 4'd1) begin
            done = close_event();
            return 1'b1;
         end
         return 1'b0;
      end
      case (frame_pos)
         4'd1: begin
            operand_a = b;
            if (takes_mask(frame_op)) frame_len = 4'd2 + 4'($countones(b));
         end
         4'd2: operand_b = b;
         4'd3: operand_c = b;
         default: ;
      endcase
      // voice bytes of a note: remember the first one that carries a pitch
      if (frame_pos >= 4'd2 && frame_op == sqe_pkg::OP_NOTE &&
          lead_note == sqe_pkg::NO_NOTE && b != sqe_pkg::NO_NOTE)
         lead_note = b;
      frame_pos = frame_pos + 4'd1;
      if (frame_pos >= frame_len) begin
         done = close_event();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // request side: one byte per transaction, random idle before each
   // called and returns at a falling edge
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input sqe_pkg::event_type want = '0);
      sqe_pkg::event_type got;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (frame_byte(b, got)) begin
         if (typed) got = want;
         pending_events = {pending_events, got};
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   // mostly well-formed events with random content, some stray bytes
   task automatic send_random_event();
      int unsigned pick;
      logic [7:0]  op;
      logic [7:0]  mask;
      logic [3:0]  len;
      bit          all_rest;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // stray byte: knocks the framing off until some event closes
         send_byte(8'($urandom));
         return;
      end else if (pick < 38) begin
         op = sqe_pkg::OP_NOTE;
      end else if (pick < 46) begin
         op = sqe_pkg::OP_TIE;
      end else if (pick < 58) begin
         case ($urandom_range(2))
            0: op = sqe_pkg::OP_SET_LENGTH;
            1: op = sqe_pkg::OP_SET_MULTIPLIER;
            default: op = sqe_pkg::OP_SET_VOICES;
         endcase
      end else if (pick < 80) begin
         op = 8'($urandom_range(sqe_pkg::OP_TABLE_LAST));
      end else if (pick < 92) begin
         op = ($urandom_range(3) == 0) ? sqe_pkg::OP_VOICE_BLOCK :
              8'($urandom_range(sqe_pkg::OP_BLOCK_LAST, sqe_pkg::OP_BLOCK_FIRST));
      end else begin
         op = ($urandom_range(1) == 0) ?
              8'($urandom_range(OP_UNKNOWN_LOW_LAST, OP_UNKNOWN_LOW_FIRST)) :
              8'($urandom_range(OP_UNKNOWN_HIGH_LAST, OP_UNKNOWN_HIGH_FIRST));
      end
      send_byte(op);
      if (takes_mask(op)) begin
         mask = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom);
         send_byte(mask);
         // in a quarter of the mask events every voice byte is empty, so such a note is a rest
         all_rest = ($urandom_range(3) == 0);
         repeat ($countones(mask))
            send_byte((all_rest || $urandom_range(2) == 0) ?
                      sqe_pkg::NO_NOTE : 8'($urandom));
      end else begin
         len = event_length_of(op);
         for (int i = 1; i < len; i++) begin
            // zero and all-ones operands often: zero counts, zero lengths, top addresses
            pick = $urandom_range(7);
            send_byte(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // response side: random backpressure, checked at the rising edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      sqe_pkg::event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_events.size() == 0) begin
            $error("result with no event pending, opcode %0h", rsp_bus.opcode);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            compare_field("opcode", 16'(want.opcode), 16'(rsp_bus.opcode));
            compare_field("event_bytes", 16'(want.event_bytes), 16'(rsp_bus.event_bytes));
            compare_field("event_kind", 16'(want.event_kind), 16'(rsp_bus.event_kind));
            compare_field("duration", want.duration, rsp_bus.duration);
            compare_field("note_byte", 16'(want.note_byte), 16'(rsp_bus.note_byte));
            compare_field("flow_kind", 16'(want.flow_kind), 16'(rsp_bus.flow_kind));
            compare_field("repeat_count", 16'(want.repeat_count),
                          16'(rsp_bus.repeat_count));
            compare_field("repeat_slot", 16'(want.repeat_slot), 16'(rsp_bus.repeat_slot));
            compare_field("target_address", want.target_address, rsp_bus.target_address);
            compare_field("voice_mask", 16'(want.voice_mask), 16'(rsp_bus.voice_mask));
         end
      end
   end

   // watchdog: too long with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;

      // directed: values read straight off the decode rules
      // return right after reset, no settings yet
      add_row(sqe_pkg::OP_RETURN, 1'b1,
         event_of(sqe_pkg::OP_RETURN, 4'd1, sqe_pkg::KIND_COMMAND, 16'd0, sqe_pkg::NO_NOTE,
                  sqe_pkg::FLOW_RETURN, 9'd0, 1'b0, 16'd0, 8'h00));
      // tie with zero length still lasts one tick
      add_row(sqe_pkg::OP_TIE, 1'b1,
         event_of(sqe_pkg::OP_TIE, 4'd1, sqe_pkg::KIND_TIE, 16'd1, sqe_pkg::NO_NOTE,
                  sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'h00));
      // largest length and multiplier
      add_row(sqe_pkg::OP_SET_LENGTH, 1'b0, '0);
      add_row(8'hFF, 1'b1,
         event_of(sqe_pkg::OP_SET_LENGTH, 4'd2, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'h00));
      add_row(sqe_pkg::OP_SET_MULTIPLIER, 1'b0, '0);
      add_row(8'hFF, 1'b1,
         event_of(sqe_pkg::OP_SET_MULTIPLIER, 4'd2, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'h00));
      // longest event: all eight voices, first pitched voice sits late
      add_row(sqe_pkg::OP_NOTE, 1'b0, '0);
      add_row(8'hFF, 1'b0, '0);
      repeat (6) add_row(sqe_pkg::NO_NOTE, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(sqe_pkg::NO_NOTE, 1'b1,
         event_of(sqe_pkg::OP_NOTE, 4'd10, sqe_pkg::KIND_NOTE, 16'd65025, 8'h00,
                  sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'h00));
      // voice mask shows up in the same transaction that sets it
      add_row(sqe_pkg::OP_SET_VOICES, 1'b0, '0);
      add_row(8'hFF, 1'b1,
         event_of(sqe_pkg::OP_SET_VOICES, 4'd2, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'hFF));
      // repeat with zero count means 256
      add_row(sqe_pkg::OP_REPEAT_START_0, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(8'h34, 1'b0, '0);
      add_row(8'h12, 1'b1,
         event_of(sqe_pkg::OP_REPEAT_START_0, 4'd4, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_REPEAT_START, 9'd256, 1'b0, 16'h1234,
                  8'hFF));
      // last block opcode with an empty mask
      add_row(sqe_pkg::OP_BLOCK_LAST, 1'b0, '0);
      add_row(8'h00, 1'b1,
         event_of(sqe_pkg::OP_BLOCK_LAST, 4'd2, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'hFF));
      // top unknown opcode
      add_row(OP_UNKNOWN_HIGH_LAST, 1'b1,
         event_of(OP_UNKNOWN_HIGH_LAST, 4'd1, sqe_pkg::KIND_COMMAND, 16'd0,
                  sqe_pkg::NO_NOTE, sqe_pkg::FLOW_NONE, 9'd0, 1'b0, 16'd0, 8'hFF));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         send_byte(dir_table[i].data_byte, dir_table[i].typed, dir_table[i].want);

      // random phases; before each one the sender holds off until all results are in
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
         while (pending_events.size() != 0) @(negedge clock);
         case (ph)
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            3: begin idle_pct = 17; stall_pct = 17; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         for (int n = bytes_sent + PHASE_BYTES; bytes_sent < n; )
            send_random_event();
      end

      // drain: no stalls, then keep watching for stray results
      req_bus.valid <= 1'b0;
      stall_pct = 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
